FILE: design/quad_perspective_center_unit_assert.svh
// Assertion macros shared by the quad perspective center unit.
`ifndef QUAD_PERSPECTIVE_CENTER_UNIT_ASSERT_SVH
`define QUAD_PERSPECTIVE_CENTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define QPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qpc assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define QPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qpc assertion failed");

`endif

FILE: design/qpc_pkg.sv
// Types, constants and the microprogram of the quad perspective center unit.
`default_nettype none
package qpc_pkg;

  localparam int DW      = 96;   // datapath word, holds every exact intermediate
  localparam int PcW     = 6;
  localparam int CntW    = $clog2(DW);
  localparam int NumSrc  = 32;

  localparam logic [DW-1:0] AreaMin = DW'(200);
  localparam logic [DW-1:0] Mega    = DW'(1000000);

  localparam logic [15:0] WidthReset  = 16'd210;
  localparam logic [15:0] HeightReset = 16'd297;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic [15:0] corner0_x;
    logic [15:0] corner0_y;
    logic [15:0] corner1_x;
    logic [15:0] corner1_y;
    logic [15:0] corner2_x;
    logic [15:0] corner2_y;
    logic [15:0] corner3_x;
    logic [15:0] corner3_y;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] center_x;
    logic [15:0] center_y;
  } out_t;

  typedef enum logic [1:0] {ST_OK, ST_AREA, ST_SING, ST_DIV} st_t;

  typedef enum logic [2:0] {
    OP_MAC, OP_CHK_AREA, OP_CHK_SING, OP_CHK_DIV, OP_DIV_X, OP_DIV_Y, OP_END
  } op_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ONE, SRC_MEGA,
    SRC_X0, SRC_Y0, SRC_X1, SRC_Y1, SRC_X2, SRC_Y2, SRC_X3, SRC_Y3,
    SRC_W, SRC_H, SRC_WH2, SRC_HH2,
    SRC_DEN, SRC_SX, SRC_SY, SRC_GN, SRC_HN, SRC_AX, SRC_BX, SRC_AY, SRC_BY,
    SRC_KX, SRC_KY, SRC_WH, SRC_Q, SRC_DN
  } src_t;

  typedef enum logic [4:0] {
    DST_NONE, DST_S, DST_DEN, DST_SX, DST_SY, DST_GN, DST_HN, DST_AX, DST_BX,
    DST_AY, DST_BY, DST_KX, DST_KY, DST_WH, DST_Q, DST_DN, DST_LHS, DST_NX, DST_NY
  } dst_t;

  // acc = (clr ? 0 : acc) +/- (a1 - a2) * (b1 - b2); stored to dst
  typedef struct packed {
    op_t  op;
    src_t a1;
    src_t a2;
    src_t b1;
    src_t b2;
    logic clr;
    logic neg;
    dst_t dst;
  } instr_t;

  typedef struct packed {
    logic   load_in;
    logic   mac_load;
    logic   mac_abs;
    logic   mac_step;
    logic   mac_acc;
    logic   div_load;
    logic   div_abs;
    logic   div_prep;
    logic   div_step;
    logic   div_store;
    logic   div_y;
    logic   publish;
    st_t    status;
    instr_t ins;
  } cmd_t;

  typedef struct packed {
    logic mb_zero;
    logic area_fail;
    logic sing_fail;
    logic div_fail;
  } stat_t;

  function automatic instr_t mac(src_t a1, src_t a2, src_t b1, src_t b2,
                                 logic clr, logic neg, dst_t dst);
    instr_t r;
    r.op  = OP_MAC;
    r.a1  = a1;
    r.a2  = a2;
    r.b1  = b1;
    r.b2  = b2;
    r.clr = clr;
    r.neg = neg;
    r.dst = dst;
    return r;
  endfunction

  function automatic instr_t ctl(op_t op);
    instr_t r;
    r     = '0;
    r.op  = op;
    return r;
  endfunction

  // Closed-form elimination; smaller factor goes on the b side.
  function automatic instr_t prog(logic [PcW-1:0] pc);
    instr_t r;
    case (pc)
      6'd0:  r = mac(SRC_Y1, SRC_Y3, SRC_X0, SRC_ZERO, 1'b1, 1'b0, DST_NONE);
      6'd1:  r = mac(SRC_Y2, SRC_Y0, SRC_X1, SRC_ZERO, 1'b0, 1'b0, DST_NONE);
      6'd2:  r = mac(SRC_Y3, SRC_Y1, SRC_X2, SRC_ZERO, 1'b0, 1'b0, DST_NONE);
      6'd3:  r = mac(SRC_Y0, SRC_Y2, SRC_X3, SRC_ZERO, 1'b0, 1'b0, DST_S);
      6'd4:  r = ctl(OP_CHK_AREA);
      6'd5:  r = mac(SRC_X1, SRC_X2, SRC_Y3, SRC_Y2, 1'b1, 1'b0, DST_NONE);
      6'd6:  r = mac(SRC_Y1, SRC_Y2, SRC_X3, SRC_X2, 1'b0, 1'b1, DST_DEN);
      6'd7:  r = ctl(OP_CHK_SING);
      6'd8:  r = mac(SRC_X0, SRC_X1, SRC_ONE, SRC_ZERO, 1'b1, 1'b0, DST_NONE);
      6'd9:  r = mac(SRC_X2, SRC_X3, SRC_ONE, SRC_ZERO, 1'b0, 1'b0, DST_SX);
      6'd10: r = mac(SRC_Y0, SRC_Y1, SRC_ONE, SRC_ZERO, 1'b1, 1'b0, DST_NONE);
      6'd11: r = mac(SRC_Y2, SRC_Y3, SRC_ONE, SRC_ZERO, 1'b0, 1'b0, DST_SY);
      6'd12: r = mac(SRC_SX, SRC_ZERO, SRC_Y3, SRC_Y2, 1'b1, 1'b0, DST_NONE);
      6'd13: r = mac(SRC_SY, SRC_ZERO, SRC_X3, SRC_X2, 1'b0, 1'b1, DST_GN);
      6'd14: r = mac(SRC_SY, SRC_ZERO, SRC_X1, SRC_X2, 1'b1, 1'b0, DST_NONE);
      6'd15: r = mac(SRC_SX, SRC_ZERO, SRC_Y1, SRC_Y2, 1'b0, 1'b1, DST_HN);
      6'd16: r = mac(SRC_DEN, SRC_ZERO, SRC_X1, SRC_X0, 1'b1, 1'b0, DST_NONE);
      6'd17: r = mac(SRC_GN, SRC_ZERO, SRC_X1, SRC_ZERO, 1'b0, 1'b0, DST_AX);
      6'd18: r = mac(SRC_DEN, SRC_ZERO, SRC_X3, SRC_X0, 1'b1, 1'b0, DST_NONE);
      6'd19: r = mac(SRC_HN, SRC_ZERO, SRC_X3, SRC_ZERO, 1'b0, 1'b0, DST_BX);
      6'd20: r = mac(SRC_DEN, SRC_ZERO, SRC_Y1, SRC_Y0, 1'b1, 1'b0, DST_NONE);
      6'd21: r = mac(SRC_GN, SRC_ZERO, SRC_Y1, SRC_ZERO, 1'b0, 1'b0, DST_AY);
      6'd22: r = mac(SRC_DEN, SRC_ZERO, SRC_Y3, SRC_Y0, 1'b1, 1'b0, DST_NONE);
      6'd23: r = mac(SRC_HN, SRC_ZERO, SRC_Y3, SRC_ZERO, 1'b0, 1'b0, DST_BY);
      6'd24: r = mac(SRC_H, SRC_ZERO, SRC_WH2, SRC_ZERO, 1'b1, 1'b0, DST_KX);
      6'd25: r = mac(SRC_W, SRC_ZERO, SRC_HH2, SRC_ZERO, 1'b1, 1'b0, DST_KY);
      6'd26: r = mac(SRC_W, SRC_ZERO, SRC_H, SRC_ZERO, 1'b1, 1'b0, DST_WH);
      6'd27: r = mac(SRC_DEN, SRC_ZERO, SRC_WH, SRC_ZERO, 1'b1, 1'b0, DST_Q);
      6'd28: r = mac(SRC_GN, SRC_ZERO, SRC_KX, SRC_ZERO, 1'b1, 1'b0, DST_NONE);
      6'd29: r = mac(SRC_HN, SRC_ZERO, SRC_KY, SRC_ZERO, 1'b0, 1'b0, DST_NONE);
      6'd30: r = mac(SRC_Q, SRC_ZERO, SRC_ONE, SRC_ZERO, 1'b0, 1'b0, DST_DN);
      6'd31: r = mac(SRC_DN, SRC_ZERO, SRC_MEGA, SRC_ZERO, 1'b1, 1'b0, DST_LHS);
      6'd32: r = ctl(OP_CHK_DIV);
      6'd33: r = mac(SRC_AX, SRC_ZERO, SRC_KX, SRC_ZERO, 1'b1, 1'b0, DST_NONE);
      6'd34: r = mac(SRC_BX, SRC_ZERO, SRC_KY, SRC_ZERO, 1'b0, 1'b0, DST_NONE);
      6'd35: r = mac(SRC_Q, SRC_ZERO, SRC_X0, SRC_ZERO, 1'b0, 1'b0, DST_NX);
      6'd36: r = mac(SRC_AY, SRC_ZERO, SRC_KX, SRC_ZERO, 1'b1, 1'b0, DST_NONE);
      6'd37: r = mac(SRC_BY, SRC_ZERO, SRC_KY, SRC_ZERO, 1'b0, 1'b0, DST_NONE);
      6'd38: r = mac(SRC_Q, SRC_ZERO, SRC_Y0, SRC_ZERO, 1'b0, 1'b0, DST_NY);
      6'd39: r = ctl(OP_DIV_X);
      6'd40: r = ctl(OP_DIV_Y);
      default: r = ctl(OP_END);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/qpc_ctrl.sv
// Sequencer: steps the microprogram and drives the datapath, owns the handshakes.
`default_nettype none
module qpc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  qpc_pkg::stat_t sts,
  output qpc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_MLOAD, S_MABS, S_MSTEP, S_MACC,
    S_DLOAD, S_DABS, S_DPREP, S_DSTEP, S_DSTORE, S_PUB
  } state_t;

  state_t                      state;
  logic [qpc_pkg::PcW-1:0]     pc;
  logic [qpc_pkg::CntW-1:0]    cnt;
  qpc_pkg::st_t                st;
  qpc_pkg::instr_t             ins;
  logic                        pub_ok;

  assign ins      = qpc_pkg::prog(pc);
  assign in_ready = (state == S_IDLE);
  assign pub_ok   = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.ins       = ins;
    cmd.status    = st;
    cmd.div_y     = (ins.op == qpc_pkg::OP_DIV_Y);
    cmd.load_in   = in_valid && (state == S_IDLE);
    cmd.mac_load  = (state == S_MLOAD);
    cmd.mac_abs   = (state == S_MABS);
    cmd.mac_step  = (state == S_MSTEP);
    cmd.mac_acc   = (state == S_MACC);
    cmd.div_load  = (state == S_DLOAD);
    cmd.div_abs   = (state == S_DABS);
    cmd.div_prep  = (state == S_DPREP);
    cmd.div_step  = (state == S_DSTEP);
    cmd.div_store = (state == S_DSTORE);
    cmd.publish   = (state == S_PUB) && pub_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      cnt       <= '0;
      st        <= qpc_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      // in S_PUB a taken item is replaced by the new one below
      if (out_valid && out_ready && (state != S_PUB)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pc    <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          unique case (ins.op)
            qpc_pkg::OP_MAC: state <= S_MLOAD;
            qpc_pkg::OP_CHK_AREA: begin
              if (sts.area_fail) begin
                st    <= qpc_pkg::ST_AREA;
                state <= S_PUB;
              end else pc <= pc + 1'b1;
            end
            qpc_pkg::OP_CHK_SING: begin
              if (sts.sing_fail) begin
                st    <= qpc_pkg::ST_SING;
                state <= S_PUB;
              end else pc <= pc + 1'b1;
            end
            qpc_pkg::OP_CHK_DIV: begin
              if (sts.div_fail) begin
                st    <= qpc_pkg::ST_DIV;
                state <= S_PUB;
              end else pc <= pc + 1'b1;
            end
            qpc_pkg::OP_DIV_X, qpc_pkg::OP_DIV_Y: state <= S_DLOAD;
            default: begin
              st    <= qpc_pkg::ST_OK;
              state <= S_PUB;
            end
          endcase
        end
        S_MLOAD: state <= S_MABS;
        S_MABS:  state <= S_MSTEP;
        S_MSTEP: begin
          if (sts.mb_zero) state <= S_MACC;
        end
        S_MACC: begin
          pc    <= pc + 1'b1;
          state <= S_FETCH;
        end
        S_DLOAD: state <= S_DABS;
        S_DABS:  state <= S_DPREP;
        S_DPREP: begin
          cnt   <= '0;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          if (cnt == qpc_pkg::CntW'(qpc_pkg::DW - 1)) state <= S_DSTORE;
          else cnt <= cnt + 1'b1;
        end
        S_DSTORE: begin
          pc    <= pc + 1'b1;
          state <= S_FETCH;
        end
        S_PUB: begin
          if (pub_ok) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/qpc_dp.sv
// Datapath: operand registers, serial multiply-accumulate, restoring divider, result.
`default_nettype none
module qpc_dp (
  input  logic           clk,
  input  logic           rst,
  input  qpc_pkg::cmd_t  cmd,
  output qpc_pkg::stat_t sts,
  input  qpc_pkg::in_t   in_data,
  output qpc_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data
);

  localparam int DW = qpc_pkg::DW;

  logic [15:0]   w_r, h_r;
  qpc_pkg::in_t  in_r;
  logic [DW-1:0] s_r, den_r, sx_r, sy_r, gn_r, hn_r, ax_r, bx_r, ay_r, by_r;
  logic [DW-1:0] kx_r, ky_r, wh_r, q_r, dn_r, lhs_r, nx_r, ny_r;
  logic [DW-1:0] ma, mb, prod, acc, acc_base, acc_new;
  logic          msign, flip;
  logic [DW-1:0] dnum, dden;
  logic [DW:0]   drem, rem_sh;
  logic [15:0]   dquo, qfin;
  logic          dneg, ge;
  logic [15:0]   cx, cy;
  logic [DW-1:0] lhs_abs, q_abs;
  logic [DW-1:0] srcv [qpc_pkg::NumSrc];
  qpc_pkg::out_t out_r;

  always_comb begin
    for (int i = 0; i < qpc_pkg::NumSrc; i++) srcv[i] = '0;
    srcv[qpc_pkg::SRC_ONE]  = DW'(1);
    srcv[qpc_pkg::SRC_MEGA] = qpc_pkg::Mega;
    srcv[qpc_pkg::SRC_X0]   = DW'(in_r.corner0_x);
    srcv[qpc_pkg::SRC_Y0]   = DW'(in_r.corner0_y);
    srcv[qpc_pkg::SRC_X1]   = DW'(in_r.corner1_x);
    srcv[qpc_pkg::SRC_Y1]   = DW'(in_r.corner1_y);
    srcv[qpc_pkg::SRC_X2]   = DW'(in_r.corner2_x);
    srcv[qpc_pkg::SRC_Y2]   = DW'(in_r.corner2_y);
    srcv[qpc_pkg::SRC_X3]   = DW'(in_r.corner3_x);
    srcv[qpc_pkg::SRC_Y3]   = DW'(in_r.corner3_y);
    srcv[qpc_pkg::SRC_W]    = DW'(w_r);
    srcv[qpc_pkg::SRC_H]    = DW'(h_r);
    srcv[qpc_pkg::SRC_WH2]  = DW'(w_r[15:1]);
    srcv[qpc_pkg::SRC_HH2]  = DW'(h_r[15:1]);
    srcv[qpc_pkg::SRC_DEN]  = den_r;
    srcv[qpc_pkg::SRC_SX]   = sx_r;
    srcv[qpc_pkg::SRC_SY]   = sy_r;
    srcv[qpc_pkg::SRC_GN]   = gn_r;
    srcv[qpc_pkg::SRC_HN]   = hn_r;
    srcv[qpc_pkg::SRC_AX]   = ax_r;
    srcv[qpc_pkg::SRC_BX]   = bx_r;
    srcv[qpc_pkg::SRC_AY]   = ay_r;
    srcv[qpc_pkg::SRC_BY]   = by_r;
    srcv[qpc_pkg::SRC_KX]   = kx_r;
    srcv[qpc_pkg::SRC_KY]   = ky_r;
    srcv[qpc_pkg::SRC_WH]   = wh_r;
    srcv[qpc_pkg::SRC_Q]    = q_r;
    srcv[qpc_pkg::SRC_DN]   = dn_r;
  end

  // accumulate with the product's sign folded into add/subtract
  assign acc_base = cmd.ins.clr ? '0 : acc;
  assign flip     = msign ^ cmd.ins.neg;
  assign acc_new  = flip ? (acc_base - prod) : (acc_base + prod);

  assign rem_sh = {drem[DW-1:0], dnum[DW-1]};
  assign ge     = (rem_sh >= {1'b0, dden});
  assign qfin   = dneg ? (16'd0 - dquo) : dquo;

  assign lhs_abs = lhs_r[DW-1] ? ('0 - lhs_r) : lhs_r;
  assign q_abs   = q_r[DW-1] ? ('0 - q_r) : q_r;

  assign sts.mb_zero   = (mb == '0);
  assign sts.area_fail = ($signed(s_r) < $signed(qpc_pkg::AreaMin)) &&
                         ($signed(s_r) > -$signed(qpc_pkg::AreaMin));
  assign sts.sing_fail = (w_r == 16'd0) || (h_r == 16'd0) || (den_r == '0);
  assign sts.div_fail  = (lhs_abs < q_abs);

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_r <= qpc_pkg::WidthReset;
      h_r <= qpc_pkg::HeightReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qpc_pkg::CfgWidth:  w_r <= cfg_data;
        qpc_pkg::CfgHeight: h_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;

    if (cmd.mac_load) begin
      ma <= srcv[cmd.ins.a1] - srcv[cmd.ins.a2];
      mb <= srcv[cmd.ins.b1] - srcv[cmd.ins.b2];
    end
    if (cmd.mac_abs) begin
      msign <= ma[DW-1] ^ mb[DW-1];
      ma    <= ma[DW-1] ? ('0 - ma) : ma;
      mb    <= mb[DW-1] ? ('0 - mb) : mb;
      prod  <= '0;
    end
    if (cmd.mac_step) begin
      if (mb[0]) prod <= prod + ma;
      ma <= ma << 1;
      mb <= mb >> 1;
    end
    if (cmd.mac_acc) begin
      acc <= acc_new;
      case (cmd.ins.dst)
        qpc_pkg::DST_S:   s_r   <= acc_new;
        qpc_pkg::DST_DEN: den_r <= acc_new;
        qpc_pkg::DST_SX:  sx_r  <= acc_new;
        qpc_pkg::DST_SY:  sy_r  <= acc_new;
        qpc_pkg::DST_GN:  gn_r  <= acc_new;
        qpc_pkg::DST_HN:  hn_r  <= acc_new;
        qpc_pkg::DST_AX:  ax_r  <= acc_new;
        qpc_pkg::DST_BX:  bx_r  <= acc_new;
        qpc_pkg::DST_AY:  ay_r  <= acc_new;
        qpc_pkg::DST_BY:  by_r  <= acc_new;
        qpc_pkg::DST_KX:  kx_r  <= acc_new;
        qpc_pkg::DST_KY:  ky_r  <= acc_new;
        qpc_pkg::DST_WH:  wh_r  <= acc_new;
        qpc_pkg::DST_Q:   q_r   <= acc_new;
        qpc_pkg::DST_DN:  dn_r  <= acc_new;
        qpc_pkg::DST_LHS: lhs_r <= acc_new;
        qpc_pkg::DST_NX:  nx_r  <= acc_new;
        qpc_pkg::DST_NY:  ny_r  <= acc_new;
        default: ;
      endcase
    end

    // round half away from zero: (2|n| + |d|) / (2|d|)
    if (cmd.div_load) begin
      dnum <= cmd.div_y ? ny_r : nx_r;
      dden <= dn_r;
    end
    if (cmd.div_abs) begin
      dneg <= dnum[DW-1] ^ dden[DW-1];
      dnum <= dnum[DW-1] ? ('0 - dnum) : dnum;
      dden <= dden[DW-1] ? ('0 - dden) : dden;
    end
    if (cmd.div_prep) begin
      dnum <= (dnum << 1) + dden;
      dden <= dden << 1;
      drem <= '0;
      dquo <= '0;
    end
    if (cmd.div_step) begin
      drem <= ge ? (rem_sh - {1'b0, dden}) : rem_sh;
      dquo <= {dquo[14:0], ge};
      dnum <= dnum << 1;
    end
    if (cmd.div_store) begin
      if (cmd.div_y) cy <= qfin;
      else cx <= qfin;
    end

    if (cmd.publish) begin
      out_r.status   <= cmd.status;
      out_r.center_x <= (cmd.status == qpc_pkg::ST_OK) ? cx : 16'd0;
      out_r.center_y <= (cmd.status == qpc_pkg::ST_OK) ? cy : 16'd0;
    end
  end

endmodule
`default_nettype wire

FILE: design/quad_perspective_center_unit.sv
// Top level of the quad perspective center unit: sequencer plus datapath.
//
//   channel | signals                           | transfer
//   input   | in_valid, in_ready, in_data       | four corners, valid/ready
//   output  | out_valid, out_ready, out_data    | status and center, valid/ready
//   config  | cfg_we, cfg_index, cfg_data       | width/height write, no wait
//
// One item at a time; the time from acceptance to a valid result is set by the
// bit-serial multiplier, which shifts until its multiplier is zero, and by two
// 96-step restoring divisions. Small-area rejects finish at the area check,
// singular ones at the singularity check.
// A finished result waits in the output register; the next item is taken
// while it waits and stalls only at its own publish step.
// Reset restores width 210 and height 297.
`default_nettype none
module quad_perspective_center_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qpc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qpc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);

  qpc_pkg::cmd_t  cmd;
  qpc_pkg::stat_t sts;
  logic           reject_out;

  qpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qpc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  assign reject_out = out_valid && (out_data.status != qpc_pkg::ST_OK);

`include "quad_perspective_center_unit_assert.svh"

  `QPC_ASSERT_NXT(busy_after_accept, in_valid && in_ready, !in_ready)
  `QPC_ASSERT_NXT(no_instant_result, in_valid && in_ready, !$rose(out_valid))
  `QPC_ASSERT_IMP(reject_zero_center, reject_out, {out_data.center_x, out_data.center_y} == '0)

endmodule
`default_nettype wire
